### rtl/lle_pkg.sv
// Shared types, constants and character functions of the log line escaper.
`default_nettype none

package lle_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [LEN_W-1:0] CAPACITY_RESET = 16'd63994;

	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_X = 8'h78;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;

	typedef enum logic [2:0] {
		CMD_CHAR,
		CMD_BSL,
		CMD_HEX,
		CMD_TRUNC,
		CMD_DONE
	} cmd_t;

	typedef logic [2:0] step_t;

	typedef struct packed {
		cmd_t cmd;
		logic [BYTE_W-1:0] data;
	} cmd_entry_t;

	typedef struct packed {
		logic push;
		cmd_entry_t entry;
	} front_push_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic done;
		logic last;
	} out_char_t;

	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
		logic [BYTE_W-1:0] res;
		if (nib < 4'd10) begin
			res = CH_ZERO + {4'd0, nib};
		end else begin
			res = CH_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return res;
	endfunction

	function automatic out_char_t esc_char(input cmd_entry_t e, input step_t step);
		out_char_t c;
		c.data = '0;
		c.done = 1'b0;
		c.last = 1'b0;
		case (e.cmd)
			CMD_CHAR: begin
				c.data = e.data;
				c.last = 1'b1;
			end
			CMD_BSL: begin
				c.data = CH_BSLASH;
				c.last = (step == 3'd1);
			end
			CMD_HEX: begin
				case (step)
					3'd0: c.data = CH_BSLASH;
					3'd1: c.data = CH_X;
					3'd2: c.data = hex_digit(e.data[7:4]);
					default: begin
						c.data = hex_digit(e.data[3:0]);
						c.last = 1'b1;
					end
				endcase
			end
			CMD_TRUNC: begin
				case (step)
					3'd0: c.data = CH_SPACE;
					3'd1, 3'd2, 3'd3: c.data = CH_DOT;
					default: begin
						c.done = 1'b1;
						c.last = 1'b1;
					end
				endcase
			end
			CMD_DONE: begin
				c.done = 1'b1;
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/lle_if.sv
// Valid/ready channel interfaces for input bytes and escaped output characters.
`default_nettype none

interface lle_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lle_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic line_done;
	logic last;

	modport source (output valid, output out_byte, output line_done, output last, input ready);
	modport sink (input valid, input out_byte, input line_done, input last, output ready);
endinterface

`default_nettype wire

### rtl/log_line_escaper_unit.sv
// Log line escaper: splits a byte stream into escaped, length-limited log lines.
//
// Requests arrive on in_ch, one raw byte or an end-of-stream mark each, and are
// taken in any cycle in which the command queue has room. Results leave on
// out_ch as single characters; a result with line_done set closes a line, and
// last marks the final result caused by one request. A printable byte gives one
// result, a backslash two, any other byte four, a truncation five, a line end
// one; newlines after truncation, empty lines and dropped bytes give none.
// The results of a request pass through the queue and the output register. The
// output serializer emits one character per cycle while the receiver takes
// them, so a request holds it for each of its results (about four for binary
// data); requests with no result skip the queue, one per cycle while it has room.
// The line capacity register is written through cfg_wr_en and cfg_wr_data;
// the user must do so only while the block is idle; it does not enforce this.
// Reset clears the line state, the queue and the output register and sets the
// capacity to its default. When the receiver stalls, the output register holds
// its character, the queue fills and in_ch.ready falls until room frees up.
`default_nettype none

module log_line_escaper_unit #(
	parameter int unsigned QUEUE_DEPTH = lle_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [lle_pkg::LEN_W-1:0] cfg_wr_data,
	lle_in_if.sink in_ch,
	lle_out_if.source out_ch
);
	import lle_pkg::*;

	front_push_t push;
	cmd_entry_t head;
	logic head_valid;
	logic queue_full;
	logic pop;

	lle_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.queue_full(queue_full),
		.push(push)
	);

	lle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head(head),
		.head_valid(head_valid),
		.full(queue_full)
	);

	lle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_valid(head_valid),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule

`default_nettype wire

### rtl/lle_front.sv
// Front end: accepts requests, tracks line length and queues escape commands.
`default_nettype none

module lle_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [lle_pkg::LEN_W-1:0] cfg_wr_data,
	lle_in_if.sink in_ch,
	input wire logic queue_full,
	output lle_pkg::front_push_t push
);
	import lle_pkg::*;

	logic [LEN_W-1:0] cap_q;
	logic [LEN_W-1:0] len_q;
	logic trunc_q;

	logic accept;
	logic is_end;
	logic [2:0] esc_len;
	logic [LEN_W:0] sum;
	logic [LEN_W-1:0] len_d;
	logic trunc_d;

	assign in_ch.ready = !queue_full;
	assign accept = in_ch.valid && in_ch.ready;
	assign is_end = in_ch.end_of_stream || (in_ch.in_byte == CH_NEWLINE);

	always_comb begin
		if (in_ch.in_byte == CH_BSLASH) begin
			esc_len = 3'd2;
		end else if (in_ch.in_byte inside {[CH_SPACE:CH_TILDE]}) begin
			esc_len = 3'd1;
		end else begin
			esc_len = 3'd4;
		end
	end

	assign sum = {1'b0, len_q} + {{(LEN_W-2){1'b0}}, esc_len};

	always_comb begin
		push.push = 1'b0;
		push.entry.cmd = CMD_CHAR;
		push.entry.data = in_ch.in_byte;
		len_d = len_q;
		trunc_d = trunc_q;
		if (is_end) begin
			push.push = accept && !trunc_q && (len_q != '0);
			push.entry.cmd = CMD_DONE;
			len_d = '0;
			trunc_d = 1'b0;
		end else if (!trunc_q) begin
			push.push = accept;
			if (sum >= {1'b0, cap_q}) begin
				push.entry.cmd = CMD_TRUNC;
				trunc_d = 1'b1;
			end else begin
				case (esc_len)
					3'd1: push.entry.cmd = CMD_CHAR;
					3'd2: push.entry.cmd = CMD_BSL;
					default: push.entry.cmd = CMD_HEX;
				endcase
				len_d = sum[LEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
			len_q <= '0;
			trunc_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (accept) begin
				len_q <= len_d;
				trunc_q <= trunc_d;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lle_queue.sv
// Small command queue between the front end and the serializer.
`default_nettype none

module lle_queue #(
	parameter int unsigned DEPTH = lle_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lle_pkg::front_push_t push,
	input wire logic pop,
	output lle_pkg::cmd_entry_t head,
	output logic head_valid,
	output logic full
);
	import lle_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push.push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lle_back.sv
// Back end: expands commands, one character per cycle while not stalled.
`default_nettype none

module lle_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire lle_pkg::cmd_entry_t head,
	input wire logic head_valid,
	output logic pop,
	lle_out_if.source out_ch
);
	import lle_pkg::*;

	step_t step_q;
	logic out_valid_q;
	out_char_t out_q;
	out_char_t cur;
	logic load;

	assign cur = esc_char(head, step_q);
	assign load = !out_valid_q || out_ch.ready;
	assign pop = load && head_valid && cur.last;

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_byte = out_q.data;
	assign out_ch.line_done = out_q.done;
	assign out_ch.last = out_q.last;

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= cur.last ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lle_checker.sv
// Port-level assertions for the log line escaper and their binding.
`default_nettype none

module lle_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] out_byte,
	input wire logic line_done,
	input wire logic last
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(line_done) && $stable(last))
	else $error("Stalled result changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> (out_byte == 8'h00))
	else $error("Line end result carries a byte.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last)
	else $error("Line end result is not the last of its request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && line_done ##1 out_valid && out_ready) |-> !line_done)
	else $error("Two line ends in a row.");

endmodule

bind log_line_escaper_unit lle_checker u_lle_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_byte(out_ch.out_byte),
	.line_done(out_ch.line_done),
	.last(out_ch.last)
);

`default_nettype wire

### bench/tb.sv
// Testbench for the log line escaper: directed table plus random bytes checked by a predictor.
`timescale 1ns / 100ps

module tb;
	import lle_pkg::*;

	localparam int DIR_ROWS = 25;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 19;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam string HEX_SET = "0123456789ABCDEF";

	typedef struct {
		bit cap_wr;
		logic [LEN_W-1:0] cap;
		logic [BYTE_W-1:0] b;
		bit eos;
		bit typed;
		string chars;
		bit closes;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [LEN_W-1:0] cfg_wr_data;

	lle_in_if in_ch ();
	lle_out_if out_ch ();

	log_line_escaper_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [LEN_W-1:0] line_len;
	logic [LEN_W-1:0] cap_value;
	bit line_cut;
	out_char_t expected_chars[$];
	out_char_t line_chars[$];
	out_char_t given_chars[$];
	int fails;
	bit send_quiet;
	bit recv_quiet;
	stim_row_t dir_rows [DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb NOT OK");
		$finish;
	end

	function automatic void add_char(input logic [BYTE_W-1:0] d, input logic dn);
		out_char_t c;
		c.data = d;
		c.done = dn;
		c.last = 1'b0;
		line_chars.push_back(c);
	endfunction

	// Escaped characters caused by one request, left in line_chars.
	function automatic void escape_request(input logic [BYTE_W-1:0] b, input bit eos);
		int esc;
		logic [LEN_W:0] sum;
		line_chars.delete();
		if (eos || b == CH_NEWLINE) begin
			if (!line_cut && line_len != 0) begin
				add_char('0, 1'b1);
			end
			line_len = '0;
			line_cut = 1'b0;
		end else if (!line_cut) begin
			if (b == CH_BSLASH) begin
				esc = 2;
			end else if (b >= CH_SPACE && b <= CH_TILDE) begin
				esc = 1;
			end else begin
				esc = 4;
			end
			sum = {1'b0, line_len} + (LEN_W + 1)'(esc);
			if (sum >= {1'b0, cap_value}) begin
				add_char(CH_SPACE, 1'b0);
				add_char(CH_DOT, 1'b0);
				add_char(CH_DOT, 1'b0);
				add_char(CH_DOT, 1'b0);
				add_char('0, 1'b1);
				line_cut = 1'b1;
			end else begin
				if (esc == 1) begin
					add_char(b, 1'b0);
				end else if (esc == 2) begin
					add_char(CH_BSLASH, 1'b0);
					add_char(CH_BSLASH, 1'b0);
				end else begin
					add_char(CH_BSLASH, 1'b0);
					add_char(CH_X, 1'b0);
					add_char(HEX_SET[b[7:4]], 1'b0);
					add_char(HEX_SET[b[3:0]], 1'b0);
				end
				line_len = line_len + LEN_W'(esc);
			end
		end
		if (line_chars.size() > 0) begin
			line_chars[line_chars.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic send_request(input logic [BYTE_W-1:0] b, input bit eos, input bit use_given);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.end_of_stream <= eos;
		do @(posedge clk); while (!in_ch.ready);
		escape_request(b, eos);
		if (use_given) begin
			foreach (given_chars[k]) expected_chars.push_back(given_chars[k]);
		end else begin
			foreach (line_chars[k]) expected_chars.push_back(line_chars[k]);
		end
	endtask

	task automatic drain_block();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [LEN_W-1:0] cap);
		drain_block();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_value = cap;
	endtask

	initial begin : result_check
		int stall;
		out_char_t got;
		out_char_t want;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			got.data = out_ch.out_byte;
			got.done = out_ch.line_done;
			got.last = out_ch.last;
			if (expected_chars.size() == 0) begin
				fails++;
				if (fails <= 10) begin
					$display("unexpected result: data %02h done %b last %b",
						got.data, got.done, got.last);
				end
			end else begin
				want = expected_chars.pop_front();
				if (got != want) begin
					fails++;
					if (fails <= 10) begin
						$display("mismatch: expected data %02h done %b last %b, ",
							want.data, want.done, want.last,
							"got data %02h done %b last %b",
							got.data, got.done, got.last);
					end
				end
			end
		end
	end

	initial begin : stimulus
		logic [LEN_W-1:0] phase_cap;
		logic [BYTE_W-1:0] b;
		bit eos;
		int kind;
		out_char_t c;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.in_byte <= '0;
		in_ch.end_of_stream <= 1'b0;
		fails = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		line_len = '0;
		line_cut = 1'b0;
		cap_value = CAPACITY_RESET;

		dir_rows = '{
			'{0, 16'd0, 8'h41, 0, 1, "A", 0},
			'{0, 16'd0, 8'h20, 0, 1, " ", 0},
			'{0, 16'd0, 8'h7E, 0, 1, "~", 0},
			'{0, 16'd0, 8'h5C, 0, 1, "\\\\", 0},
			'{0, 16'd0, 8'h7F, 0, 1, "\\x7F", 0},
			'{0, 16'd0, 8'h00, 0, 1, "\\x00", 0},
			'{0, 16'd0, 8'hFF, 0, 1, "\\xFF", 0},
			'{0, 16'd0, 8'h1F, 0, 0, "", 0},
			'{0, 16'd0, 8'h80, 0, 0, "", 0},
			'{0, 16'd0, 8'h0A, 0, 1, "", 1},
			'{0, 16'd0, 8'h0A, 0, 1, "", 0},
			'{0, 16'd0, 8'h7A, 0, 0, "", 0},
			'{0, 16'd0, 8'hFF, 1, 1, "", 1},
			'{0, 16'd0, 8'h0A, 1, 1, "", 0},
			'{1, 16'd8, 8'h5C, 0, 0, "", 0},
			'{0, 16'd0, 8'h5C, 0, 0, "", 0},
			'{0, 16'd0, 8'h61, 0, 0, "", 0},
			'{0, 16'd0, 8'h62, 0, 0, "", 0},
			'{0, 16'd0, 8'h63, 0, 0, "", 0},
			'{0, 16'd0, 8'h64, 0, 1, " ...", 1},
			'{0, 16'd0, 8'h00, 0, 1, "", 0},
			'{0, 16'd0, 8'h0A, 0, 1, "", 0},
			'{0, 16'd0, 8'h01, 0, 0, "", 0},
			'{0, 16'd0, 8'h02, 0, 1, " ...", 1},
			'{0, 16'd0, 8'h00, 1, 1, "", 0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].cap_wr) begin
				write_capacity(dir_rows[r].cap);
			end
			given_chars.delete();
			for (int k = 0; k < dir_rows[r].chars.len(); k++) begin
				c.data = dir_rows[r].chars[k];
				c.done = 1'b0;
				c.last = (k == dir_rows[r].chars.len() - 1) && !dir_rows[r].closes;
				given_chars.push_back(c);
			end
			if (dir_rows[r].closes) begin
				c.data = '0;
				c.done = 1'b1;
				c.last = 1'b1;
				given_chars.push_back(c);
			end
			send_request(dir_rows[r].b, dir_rows[r].eos, dir_rows[r].typed);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: phase_cap = 16'd8;
				1: phase_cap = 16'hFFFF;
				2: phase_cap = LEN_W'($urandom_range(9, 40));
				default: phase_cap = LEN_W'($urandom_range(12, 300));
			endcase
			write_capacity(phase_cap);
			send_quiet = (p == 1) || (p == 3);
			recv_quiet = (p == 2) || (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 12) begin
					drain_block();
				end
				kind = $urandom_range(0, 99);
				b = BYTE_W'($urandom_range(0, 255));
				eos = 1'b0;
				if (kind < 8) begin
					b = CH_NEWLINE;
				end else if (kind < 11) begin
					eos = 1'b1;
				end else if (kind < 19) begin
					b = CH_BSLASH;
				end else if (kind >= 40) begin
					b = BYTE_W'($urandom_range(32, 126));
				end
				send_request(b, eos, 1'b0);
			end
		end

		drain_block();
		if (fails == 0 && expected_chars.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
